// ----- rtl/core/jsu_pkg.sv -----
// Package for the JSON string unescaper: mode type, result kinds, the word
// and state structures, and the hex digit helper.
// No dependencies.
package jsu_pkg;

    // Decoder modes.
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_STR  = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_HEX  = 2'd3
    } mode_t;

    // Result kinds carried in tuser.
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Characters of interest.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_U     = 8'h75;

    // Maximum words produced by one input word.
    localparam int MaxRes = 3;

    // One result word.
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } res_t;

    // Decoder state.
    typedef struct packed {
        mode_t       mode;
        logic [1:0]  hex_count;
        logic [15:0] code_accum;
        logic        hex_stopped;
    } state_t;

    // Results of one step: count and up to three words, lowest first.
    typedef struct packed {
        logic [1:0]         cnt;
        res_t [MaxRes-1:0]  res;
    } step_res_t;

    // Hex digit value; bit 4 set means the character is a valid digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = {1'b1, c[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

// ----- rtl/core/jsu_decode.sv -----
// Combinational decode step of the JSON string unescaper: next state and the
// result words for one input word.
// Depends on jsu_pkg.
module jsu_decode (
    input  jsu_pkg::state_t    cur,
    input  logic [7:0]         in_byte,
    input  logic               text_ended,
    output jsu_pkg::state_t    nxt,
    output jsu_pkg::step_res_t step
);
    import jsu_pkg::*;

    logic [4:0]  hex_v;
    logic [15:0] accum_upd;
    logic        hex_take;

    // Hex digit accumulation, shared by both blocks below.
    assign hex_v     = hex_value(in_byte);
    assign hex_take  = !cur.hex_stopped && hex_v[4];
    assign accum_upd = hex_take ? {cur.code_accum[11:0], hex_v[3:0]} : cur.code_accum;

    // Next state.
    always_comb
    begin
        nxt = cur;
        if (text_ended) begin
            nxt = '{MODE_IDLE, 2'd0, 16'd0, 1'b0};
        end else begin
            unique case (cur.mode)
                MODE_IDLE:
                begin
                    if (in_byte == CH_QUOTE) begin
                        nxt.mode = MODE_STR;
                    end
                end
                MODE_STR:
                begin
                    if (in_byte == CH_QUOTE) begin
                        nxt = '{MODE_IDLE, 2'd0, 16'd0, 1'b0};
                    end else if (in_byte == CH_BSL) begin
                        nxt.mode = MODE_ESC;
                    end
                end
                MODE_ESC:
                begin
                    if (in_byte == CH_U) begin
                        nxt = '{MODE_HEX, 2'd0, 16'd0, 1'b0};
                    end else begin
                        nxt.mode = MODE_STR;
                    end
                end
                MODE_HEX:
                begin
                    if (cur.hex_count == 2'd3) begin
                        nxt = '{MODE_STR, 2'd0, 16'd0, 1'b0};
                    end else begin
                        nxt.hex_count   = cur.hex_count + 2'd1;
                        nxt.code_accum  = accum_upd;
                        nxt.hex_stopped = !hex_take;
                    end
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end
    end

    // Result words; the last one produced carries the last flag.
    always_comb
    begin
        step = '0;
        if (text_ended) begin
            step.cnt    = 2'd1;
            step.res[0] = '{8'd0, KIND_ERR, 1'b1};
        end else begin
            unique case (cur.mode)
                MODE_IDLE:
                begin
                    if (in_byte != CH_QUOTE) begin
                        step.cnt    = 2'd1;
                        step.res[0] = '{8'd0, KIND_ERR, 1'b1};
                    end
                end
                MODE_STR:
                begin
                    if (in_byte == CH_QUOTE) begin
                        step.cnt    = 2'd1;
                        step.res[0] = '{8'd0, KIND_DONE, 1'b1};
                    end else if (in_byte != CH_BSL) begin
                        step.cnt    = 2'd1;
                        step.res[0] = '{in_byte, KIND_BYTE, 1'b1};
                    end
                end
                MODE_ESC:
                begin
                    step.cnt = 2'd1;
                    unique case (in_byte)
                        CH_N:    step.res[0] = '{8'h0A, KIND_BYTE, 1'b1};
                        CH_T:    step.res[0] = '{8'h09, KIND_BYTE, 1'b1};
                        CH_R:    step.res[0] = '{8'h0D, KIND_BYTE, 1'b1};
                        CH_B:    step.res[0] = '{8'h08, KIND_BYTE, 1'b1};
                        CH_F:    step.res[0] = '{8'h0C, KIND_BYTE, 1'b1};
                        CH_U:    step.cnt    = 2'd0;
                        default: step.res[0] = '{in_byte, KIND_BYTE, 1'b1};
                    endcase
                end
                MODE_HEX:
                begin
                    // The fourth character closes the escape: encode as UTF-8.
                    if (cur.hex_count == 2'd3) begin
                        if (accum_upd < 16'h0080) begin
                            step.cnt    = 2'd1;
                            step.res[0] = '{accum_upd[7:0], KIND_BYTE, 1'b1};
                        end else if (accum_upd < 16'h0800) begin
                            step.cnt    = 2'd2;
                            step.res[0] = '{8'hC0 | {3'd0, accum_upd[10:6]}, KIND_BYTE, 1'b0};
                            step.res[1] = '{8'h80 | {2'd0, accum_upd[5:0]}, KIND_BYTE, 1'b1};
                        end else begin
                            step.cnt    = 2'd3;
                            step.res[0] = '{8'hE0 | {4'd0, accum_upd[15:12]}, KIND_BYTE, 1'b0};
                            step.res[1] = '{8'h80 | {2'd0, accum_upd[11:6]}, KIND_BYTE, 1'b0};
                            step.res[2] = '{8'h80 | {2'd0, accum_upd[5:0]}, KIND_BYTE, 1'b1};
                        end
                    end
                end
                default:
                begin
                    step = '0;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/jsu_out_queue.sv -----
// Four-word result queue of the JSON string unescaper: takes up to three
// words at once and hands them out one per ready cycle, head in entry zero.
// Depends on jsu_pkg.
module jsu_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  jsu_pkg::step_res_t step,
    output logic               room,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // out_byte[7:0]
    output logic [1:0]         m_tuser,   // kind[1:0]
    output logic               m_tlast
);
    import jsu_pkg::*;

    localparam int Depth = 4;

    res_t [Depth-1:0] q_reg;
    res_t [Depth-1:0] q_next;
    logic [2:0]       count_reg;
    logic [2:0]       count_next;
    logic [2:0]       base;
    logic [2:0]       off;
    logic             pop;

    // Head word drives the master side.
    assign m_tvalid = (count_reg != 3'd0);
    assign m_tdata  = q_reg[0].data;
    assign m_tuser  = q_reg[0].kind;
    assign m_tlast  = q_reg[0].last;
    assign pop      = m_tvalid && m_tready;

    // Words left after this cycle's pop; three new words must still fit.
    assign base = count_reg - {2'd0, pop};
    assign room = (base <= 3'd1);

    // Shift out the popped word, then append the new words behind the rest.
    always_comb
    begin
        q_next = q_reg;
        off    = 3'd0;
        for (int i = 0; i < Depth; i++) begin
            if (pop && i < Depth - 1) begin
                q_next[i] = q_reg[i+1];
            end
            off = 3'(i) - base;
            if (push && 3'(i) >= base && off < {1'b0, step.cnt}) begin
                q_next[i] = step.res[off[1:0]];
            end
        end
        count_next = base + (push ? {1'b0, step.cnt} : 3'd0);
    end

    // Fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 3'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Queue entries hold payload only.
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

// ----- rtl/core/json_string_unescape.sv -----
// Top level of the JSON string unescaper: decoder state registers, the
// decode step and the result queue.
// Depends on jsu_pkg, jsu_decode and jsu_out_queue.
//
// Streaming decoder for one quoted JSON string, one text byte per word. It
// waits for the opening quote, copies plain bytes, decodes the n t r b f
// escapes, passes other escaped bytes through, and turns a u escape of four
// hex characters into one to three UTF-8 bytes (collection of the value stops
// at the first non-hex character, but four characters are always consumed).
// The closing quote yields a completion word; end of text, or anything but a
// quote while idle, yields an error word, and the decoder is idle again. Each
// input word is decoded in the cycle it is accepted and its results enter a
// four-word output queue, so one byte is taken every cycle while results flow
// at one per cycle. The queue sets the rate: input is held off only while
// more than one result word would remain after the current cycle.
module json_string_unescape (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte[7:0]
    input  logic [0:0] s_tuser,   // text_ended[0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte[7:0]
    output logic [1:0] m_tuser,   // kind[1:0]
    output logic       m_tlast
);
    import jsu_pkg::*;

    state_t    state_reg;
    state_t    state_next;
    step_res_t step;
    logic      accept;
    logic      room;

    assign s_tready = room;
    assign accept   = s_tvalid && s_tready;

    // Decode step for the word on the slave side.
    jsu_decode u_decode (
        .cur        (state_reg),
        .in_byte    (s_tdata),
        .text_ended (s_tuser[0]),
        .nxt        (state_next),
        .step       (step)
    );

    // Result words wait here for the master side.
    jsu_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .step     (step),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Decoder state advances on each accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{MODE_IDLE, 2'd0, 16'd0, 1'b0};
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

endmodule
